### rtl/wmd_pkg.sv
`default_nettype none
package wmd_pkg;

  // Field and datapath widths
  localparam int unsigned VAL_W  = 16;
  localparam int unsigned SUM_W  = 48;
  localparam int unsigned DIST_W = 32;
  localparam int unsigned RAD_W  = 64;   // square root operand
  localparam int unsigned ROOT_W = 32;   // square root result

  localparam logic [SUM_W-1:0]  SUM_MAX = {SUM_W{1'b1}};
  localparam logic [DIST_W-1:0] OUT_MAX = {DIST_W{1'b1}};
  localparam logic [DIST_W-1:0] ONE_Q16 = 32'h0001_0000;

  // Configuration register indexes
  localparam logic CFG_R_EXP = 1'b0;
  localparam logic CFG_Q_EXP = 1'b1;

  localparam logic [15:0] R_RESET = 16'd8192;
  localparam logic [15:0] Q_RESET = 16'd4096;

endpackage
`default_nettype wire

### rtl/wmd_sqrt.sv
`default_nettype none
// Iterative floor square root, one result bit per cycle.
module wmd_sqrt (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic [wmd_pkg::RAD_W-1:0]   operand,
  output logic                             done,
  output logic [wmd_pkg::ROOT_W-1:0]       root
);

  localparam logic [wmd_pkg::RAD_W-1:0] TOP_BIT = 64'h4000_0000_0000_0000;

  logic                       busy_r;
  logic                       done_r;
  logic [4:0]                 cnt_r;
  logic [wmd_pkg::RAD_W-1:0]  v_r;
  logic [wmd_pkg::RAD_W-1:0]  res_r;
  logic [wmd_pkg::RAD_W-1:0]  bit_v;
  logic [wmd_pkg::RAD_W-1:0]  trial;

  assign bit_v = TOP_BIT >> {cnt_r, 1'b0};
  assign trial = res_r + bit_v;
  assign done  = done_r;
  assign root  = res_r[wmd_pkg::ROOT_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        v_r    <= operand;
        res_r  <= '0;
        cnt_r  <= '0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        // compare against current trial, then shift result
        if (v_r >= trial) begin
          v_r   <= v_r - trial;
          res_r <= (res_r >> 1) + bit_v;
        end else begin
          res_r <= res_r >> 1;
        end
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'd31) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

### rtl/weighted_minkowski_distance.sv
`default_nettype none
// Weighted Minkowski distance. Each input transfer carries one feature pair and
// a weight; the block adds weight*|first-second|^r to a saturating 48-bit
// accumulator and, on the transfer flagged last_element, delivers sum^(q/r) in
// Q16.16 plus a saturation flag, then clears the sum. Powers are formed as
// exp2(e*log2(x)) on one shared 33x33 multiplier, a bit-serial square root and
// a bit-serial divider, so the input is stalled while an item is worked on.
// A non-last item with a nonzero term runs normalize, 16 squarings and the
// multiply, then 16 exp2 rounds of one square root each, then weighting and
// accumulate; the exp2 square roots dominate. A zero difference or zero
// weight goes straight to accumulate, and a power outside the exp2 range
// skips the rounds. A last item adds another log2/exp2 pass and the divide,
// unless q is zero or the sum is zero. A finished result waits in the
// output register while the next item is taken.
module weighted_minkowski_distance (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [15:0] cfg_wdata,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [15:0] in_first_value,
  input  wire logic [15:0] in_second_value,
  input  wire logic [15:0] in_feature_weight,
  input  wire logic        in_last_element,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      out_distance,
  output logic             out_saturated
);

  typedef enum logic [3:0] {
    S_IDLE, S_LNORM, S_LSQ, S_EMUL, S_DIV, S_DIVFIX, S_EXP0, S_EXPB,
    S_EXPW, S_ESH, S_WM0, S_WM1, S_ACC, S_RES0, S_RES, S_EMIT
  } state_t;

  state_t               state_r;
  logic                 phase_r;      // 0: term, 1: final result
  logic [15:0]          r_exp_r;
  logic [15:0]          q_exp_r;
  logic [15:0]          w_r;
  logic                 last_r;
  logic [47:0]          x_r;
  logic [5:0]           k_r;
  logic [31:0]          m_r;
  logic [15:0]          frac_r;
  logic [5:0]           cnt_r;
  logic signed [39:0]   e_r;
  logic                 neg_r;
  logic [38:0]          dvd_r;
  logic [15:0]          rem_r;
  logic [32:0]          y_r;
  logic [15:0]          f_r;
  logic signed [5:0]    n_r;
  logic [47:0]          p_r;
  logic                 psat_r;
  logic [63:0]          acc_r;
  logic [47:0]          term_r;
  logic [47:0]          sum_r;
  logic                 ovf_r;
  logic [31:0]          res_r;
  logic                 rsat_r;
  logic                 out_valid_r;
  logic [31:0]          out_dist_r;
  logic                 out_sat_r;

  // shared multiplier
  logic signed [32:0]   mul_a;
  logic signed [32:0]   mul_b;
  logic signed [65:0]   mul_p;

  logic [15:0]          r_eff;
  logic signed [22:0]   l_sig;
  logic signed [16:0]   diff;
  logic [15:0]          dabs;
  logic [32:0]          sq;
  logic [16:0]          dtrial;
  logic [39:0]          emag;
  logic [38:0]          qadj;
  logic signed [23:0]   n_full;
  logic [32:0]          y_pre;
  logic                 sq_done;
  logic [31:0]          sq_root;
  logic [47:0]          y_wide;
  logic [5:0]           sh_amt;
  logic [63:0]          wp_tot;
  logic [55:0]          wp_sh;
  logic [48:0]          sum_add;

  assign r_eff = (r_exp_r == 16'd0) ? 16'd1 : r_exp_r;
  assign l_sig = $signed({1'b0, k_r, frac_r})
               - (phase_r ? 23'sd1048576 : 23'sd524288);
  assign diff  = $signed({in_first_value[15], in_first_value})
               - $signed({in_second_value[15], in_second_value});
  assign dabs  = diff[16] ? 16'(-diff) : diff[15:0];
  assign sq    = mul_p[63:31];
  assign dtrial = {rem_r, dvd_r[38]} - {1'b0, r_eff};
  assign emag  = mul_p[39] ? 40'(-mul_p[39:0]) : mul_p[39:0];
  assign qadj  = dvd_r + {38'd0, (neg_r && rem_r != 16'd0)};
  assign n_full = e_r[39:16];
  assign y_pre = f_r[0] ? {y_r[31:0], 1'b0} : y_r;
  assign y_wide = {15'd0, y_r};
  assign sh_amt = (n_r >= 6'sd14) ? 6'(n_r - 6'sd14) : 6'(6'sd14 - n_r);
  assign wp_tot = acc_r + {mul_p[39:0], 24'd0};
  assign wp_sh  = wp_tot[63:8];
  assign sum_add = {1'b0, sum_r} + {1'b0, term_r};

  // multiplier operand select
  always_comb begin
    case (state_r)
      S_LSQ: begin
        mul_a = {1'b0, m_r};
        mul_b = {1'b0, m_r};
      end
      S_EMUL: begin
        mul_a = 33'(l_sig);
        mul_b = {17'd0, (phase_r ? q_exp_r : r_eff)};
      end
      S_WM0: begin
        mul_a = {17'd0, w_r};
        mul_b = {9'd0, p_r[23:0]};
      end
      S_WM1: begin
        mul_a = {17'd0, w_r};
        mul_b = {9'd0, p_r[47:24]};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end
  assign mul_p = mul_a * mul_b;

  wmd_sqrt u_sqrt (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (state_r == S_EXPB),
    .operand ({1'b0, y_pre, 30'd0}),
    .done    (sq_done),
    .root    (sq_root)
  );

  assign in_stall      = (state_r != S_IDLE);
  assign out_valid     = out_valid_r;
  assign out_distance  = out_dist_r;
  assign out_saturated = out_sat_r;

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      phase_r     <= 1'b0;
      r_exp_r     <= wmd_pkg::R_RESET;
      q_exp_r     <= wmd_pkg::Q_RESET;
      sum_r       <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // result transfer frees the output register; S_EMIT refills it itself
      if (out_valid_r && !out_stall && state_r != S_EMIT) out_valid_r <= 1'b0;

      if (cfg_we) begin
        case (cfg_index)
          wmd_pkg::CFG_R_EXP: r_exp_r <= cfg_wdata;
          wmd_pkg::CFG_Q_EXP: q_exp_r <= cfg_wdata;
          default: ;
        endcase
      end

      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            w_r     <= in_feature_weight;
            last_r  <= in_last_element;
            phase_r <= 1'b0;
            x_r     <= {32'd0, dabs};
            k_r     <= 6'd47;
            term_r  <= '0;
            if (dabs == 16'd0 || in_feature_weight == 16'd0) state_r <= S_ACC;
            else state_r <= S_LNORM;
          end
        end
        // leading-one search, one bit per cycle
        S_LNORM: begin
          if (x_r[47]) begin
            m_r     <= x_r[47:16];
            frac_r  <= '0;
            cnt_r   <= '0;
            state_r <= S_LSQ;
          end else begin
            x_r <= x_r << 1;
            k_r <= k_r - 6'd1;
          end
        end
        // log2 fraction by repeated squaring
        S_LSQ: begin
          frac_r <= {frac_r[14:0], sq[32]};
          m_r    <= sq[32] ? sq[32:1] : sq[31:0];
          cnt_r  <= cnt_r + 6'd1;
          if (cnt_r == 6'd15) state_r <= S_EMUL;
        end
        S_EMUL: begin
          if (phase_r) begin
            neg_r   <= mul_p[39];
            dvd_r   <= emag[38:0];
            rem_r   <= '0;
            cnt_r   <= '0;
            state_r <= S_DIV;
          end else begin
            e_r     <= {{12{mul_p[39]}}, mul_p[39:12]};
            state_r <= S_EXP0;
          end
        end
        // restoring divide of |l*q| by r
        S_DIV: begin
          if (!dtrial[16]) begin
            rem_r <= dtrial[15:0];
            dvd_r <= {dvd_r[37:0], 1'b1};
          end else begin
            rem_r <= {rem_r[14:0], dvd_r[38]};
            dvd_r <= {dvd_r[37:0], 1'b0};
          end
          cnt_r <= cnt_r + 6'd1;
          if (cnt_r == 6'd38) state_r <= S_DIVFIX;
        end
        S_DIVFIX: begin
          e_r     <= neg_r ? -$signed({1'b0, qadj}) : $signed({1'b0, qadj});
          state_r <= S_EXP0;
        end
        // exp2 range check
        S_EXP0: begin
          if (n_full > 24'sd31) begin
            p_r     <= wmd_pkg::SUM_MAX;
            psat_r  <= 1'b1;
            state_r <= phase_r ? S_RES : S_WM0;
          end else if (n_full < -24'sd20) begin
            p_r     <= '0;
            psat_r  <= 1'b0;
            state_r <= phase_r ? S_RES : S_WM0;
          end else begin
            psat_r  <= 1'b0;
            y_r     <= 33'h0_4000_0000;
            f_r     <= e_r[15:0];
            n_r     <= e_r[21:16];
            cnt_r   <= '0;
            state_r <= S_EXPB;
          end
        end
        S_EXPB: state_r <= S_EXPW;
        S_EXPW: begin
          if (sq_done) begin
            y_r   <= {1'b0, sq_root};
            f_r   <= f_r >> 1;
            cnt_r <= cnt_r + 6'd1;
            state_r <= (cnt_r == 6'd15) ? S_ESH : S_EXPB;
          end
        end
        S_ESH: begin
          p_r     <= (n_r >= 6'sd14) ? (y_wide << sh_amt) : (y_wide >> sh_amt);
          state_r <= phase_r ? S_RES : S_WM0;
        end
        // weight times power in two partial products
        S_WM0: begin
          if (psat_r) begin
            term_r  <= wmd_pkg::SUM_MAX;
            ovf_r   <= 1'b1;
            state_r <= S_ACC;
          end else begin
            acc_r   <= {24'd0, mul_p[39:0]};
            state_r <= S_WM1;
          end
        end
        S_WM1: begin
          if (wp_sh[55:48] != 8'd0) begin
            term_r <= wmd_pkg::SUM_MAX;
            ovf_r  <= 1'b1;
          end else begin
            term_r <= wp_sh[47:0];
          end
          state_r <= S_ACC;
        end
        S_ACC: begin
          if (sum_add[48]) begin
            sum_r <= wmd_pkg::SUM_MAX;
            ovf_r <= 1'b1;
          end else begin
            sum_r <= sum_add[47:0];
          end
          state_r <= last_r ? S_RES0 : S_IDLE;
        end
        S_RES0: begin
          rsat_r <= 1'b0;
          if (q_exp_r == 16'd0) begin
            res_r   <= wmd_pkg::ONE_Q16;
            state_r <= S_EMIT;
          end else if (sum_r == '0) begin
            res_r   <= '0;
            state_r <= S_EMIT;
          end else begin
            phase_r <= 1'b1;
            x_r     <= sum_r;
            k_r     <= 6'd47;
            state_r <= S_LNORM;
          end
        end
        S_RES: begin
          if (psat_r || p_r[47:32] != 16'd0) begin
            res_r  <= wmd_pkg::OUT_MAX;
            rsat_r <= 1'b1;
          end else begin
            res_r  <= p_r[31:0];
          end
          state_r <= S_EMIT;
        end
        // wait for the output register to free up
        S_EMIT: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r <= 1'b1;
            out_dist_r  <= res_r;
            out_sat_r   <= ovf_r | rsat_r;
            sum_r       <= '0;
            ovf_r       <= 1'b0;
            phase_r     <= 1'b0;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

### rtl/wmd_checker.sv
`default_nettype none
module wmd_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [31:0] out_distance,
  input wire logic        out_saturated
);

  // held result must not change
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_distance)
                               && $stable(out_saturated))
    else $error("stalled result changed");

  // an accepted item keeps the input stalled while it is worked on
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input not stalled after transfer");

  // all-ones distance only comes from saturation
  a_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_distance == 32'hFFFF_FFFF |-> out_saturated)
    else $error("full-scale distance without saturation flag");

  // reset empties the output
  a_rst: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind weighted_minkowski_distance wmd_checker u_wmd_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_distance  (out_distance),
  .out_saturated (out_saturated)
);
`default_nettype wire
